// ----- rtl/core/vbi_line_code_placement_assert.svh -----
// assertion macros shared by the vbi line code placement checker
// expects clk and rst_n in the scope where a macro is used
`ifndef VBI_LINE_CODE_PLACEMENT_ASSERT_SVH
`define VBI_LINE_CODE_PLACEMENT_ASSERT_SVH

// same-cycle implication, off during reset
`define VLCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define VLCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/vlcp_pkg.sv -----
// types and constants for the vbi line code placement block
// no dependencies
`default_nettype none

package vlcp_pkg;

    typedef enum logic [3:0] {
        KIND_NONE     = 4'd0,
        KIND_USERS    = 4'd1,
        KIND_LEADIN   = 4'd2,
        KIND_LEADOUT  = 4'd3,
        KIND_STOP     = 4'd4,
        KIND_STATUS   = 4'd5,
        KIND_PICNUM   = 4'd6,
        KIND_CHAPTER  = 4'd7,
        KIND_CLVPIC   = 4'd8,
        KIND_TIMECODE = 4'd9,
        KIND_CLVCODE  = 4'd10,
        KIND_FMPIC    = 4'd11,
        KIND_FMTIME   = 4'd12,
        KIND_WHITE    = 4'd13
    } code_kind_t;

    typedef enum logic [1:0] {
        SEC_LEADIN    = 2'd0,
        SEC_LEADOUT   = 2'd1,
        SEC_PROGRAMME = 2'd2,
        SEC_OTHER     = 2'd3
    } section_t;

    // configuration register indexes
    localparam logic [1:0] CFG_VIDEO_STANDARD = 2'd0;
    localparam logic [1:0] CFG_DISC_KIND      = 2'd1;
    localparam logic [1:0] CFG_SECTION_KIND   = 2'd2;
    localparam logic [1:0] CFG_PRESENT_MASK   = 2'd3;

    localparam int LINE_W  = 10;
    localparam int MASK_W  = 11;
    localparam int CFG_W   = 11;
    localparam int INDEX_W = 2;

    // present mask bit positions
    localparam int MASK_USERS    = 0;
    localparam int MASK_STOP     = 1;
    localparam int MASK_STATUS   = 2;
    localparam int MASK_PICNUM   = 3;
    localparam int MASK_CHAPTER  = 4;
    localparam int MASK_CLVPIC   = 5;
    localparam int MASK_TIMECODE = 6;
    localparam int MASK_CLVCODE  = 7;
    localparam int MASK_FMPIC    = 8;
    localparam int MASK_FMTIME   = 9;
    localparam int MASK_WHITE    = 10;

    // line numbers of the reserved vertical interval
    localparam logic [LINE_W-1:0] PAL_F1_FIRST  = 10'd6;
    localparam logic [LINE_W-1:0] PAL_F2_FIRST  = 10'd319;
    localparam logic [LINE_W-1:0] PAL_F2_LAST   = 10'd331;
    localparam logic [LINE_W-1:0] PAL_F2_USERS  = 10'd329;
    localparam logic [LINE_W-1:0] PAL_F2_MARK_A = 10'd330;
    localparam logic [LINE_W-1:0] PAL_FOLD      = 10'd313;
    localparam logic [LINE_W-1:0] NTSC_F1_FIRST = 10'd10;
    localparam logic [LINE_W-1:0] NTSC_F1_WHITE = 10'd11;
    localparam logic [LINE_W-1:0] NTSC_F2_FIRST = 10'd273;
    localparam logic [LINE_W-1:0] NTSC_F2_WHITE = 10'd274;
    localparam logic [LINE_W-1:0] NTSC_F2_USERS = 10'd279;
    localparam logic [LINE_W-1:0] NTSC_F2_MARK_A = 10'd280;
    localparam logic [LINE_W-1:0] NTSC_F2_LAST  = 10'd281;
    localparam logic [LINE_W-1:0] NTSC_FOLD     = 10'd263;
    localparam logic [LINE_W-1:0] LINE_16       = 10'd16;
    localparam logic [LINE_W-1:0] LINE_17       = 10'd17;
    localparam logic [LINE_W-1:0] LINE_18       = 10'd18;

    typedef struct packed {
        logic              ntsc;
        logic              clv;
        section_t          section;
        logic [MASK_W-1:0] mask;
    } cfg_t;

    typedef struct packed {
        logic       assigned;
        code_kind_t kind;
        logic       is_fm;
        logic       white_flag;
        logic       offset_172h;
    } decision_t;

endpackage

`default_nettype wire

// ----- rtl/core/vlcp_decide.sv -----
// per-line code choice: range check, field-2 fold and priority pick
// depends on vlcp_pkg
`default_nettype none

module vlcp_decide (
    input  wire vlcp_pkg::cfg_t              cfg,
    input  wire logic [vlcp_pkg::LINE_W-1:0] line,
    output vlcp_pkg::decision_t              decision
);

    vlcp_pkg::code_kind_t          kind;
    vlcp_pkg::code_kind_t          marker;
    logic                          off;
    logic                          biphase;
    logic [vlcp_pkg::LINE_W-1:0]   canon;
    logic                          pal_range;
    logic                          ntsc_range;
    logic                          marker_sec;

    always_comb
    begin
        kind    = vlcp_pkg::KIND_NONE;
        off     = 1'b0;
        biphase = 1'b0;
        canon   = line;
        marker  = (cfg.section == vlcp_pkg::SEC_LEADIN) ? vlcp_pkg::KIND_LEADIN
                                                        : vlcp_pkg::KIND_LEADOUT;
        marker_sec = cfg.section inside {vlcp_pkg::SEC_LEADIN, vlcp_pkg::SEC_LEADOUT};
        pal_range  = (line >= vlcp_pkg::PAL_F1_FIRST && line <= vlcp_pkg::LINE_18)
                  || (line >= vlcp_pkg::PAL_F2_FIRST && line <= vlcp_pkg::PAL_F2_LAST);
        ntsc_range = (line >= vlcp_pkg::NTSC_F1_FIRST && line <= vlcp_pkg::LINE_18)
                  || (line >= vlcp_pkg::NTSC_F2_FIRST && line <= vlcp_pkg::NTSC_F2_LAST);

        if (!cfg.ntsc)
        begin
            if (pal_range && marker_sec)
            begin
                if (line == vlcp_pkg::LINE_16 || line == vlcp_pkg::PAL_F2_USERS)
                begin
                    if (cfg.mask[vlcp_pkg::MASK_USERS])
                        kind = vlcp_pkg::KIND_USERS;
                end
                else if (line == vlcp_pkg::LINE_17 || line == vlcp_pkg::LINE_18
                      || line == vlcp_pkg::PAL_F2_MARK_A || line == vlcp_pkg::PAL_F2_LAST)
                    kind = marker;
            end
            else if (pal_range && cfg.section == vlcp_pkg::SEC_PROGRAMME)
            begin
                biphase = 1'b1;
                if (line >= vlcp_pkg::PAL_F2_USERS)
                    canon = line - vlcp_pkg::PAL_FOLD;
            end
        end
        else
        begin
            if (ntsc_range && marker_sec)
            begin
                if (line == vlcp_pkg::NTSC_F1_WHITE)
                begin
                    if (cfg.mask[vlcp_pkg::MASK_WHITE])
                        kind = vlcp_pkg::KIND_WHITE;
                end
                else if (line == vlcp_pkg::NTSC_F2_WHITE)
                begin
                    // lead-in carries no white flag on this line
                    if (cfg.section == vlcp_pkg::SEC_LEADOUT && cfg.mask[vlcp_pkg::MASK_WHITE])
                        kind = vlcp_pkg::KIND_WHITE;
                end
                else if (line == vlcp_pkg::LINE_16 || line == vlcp_pkg::NTSC_F2_USERS)
                begin
                    if (cfg.mask[vlcp_pkg::MASK_USERS])
                        kind = vlcp_pkg::KIND_USERS;
                end
                else if (line == vlcp_pkg::LINE_17 || line == vlcp_pkg::LINE_18
                      || line == vlcp_pkg::NTSC_F2_MARK_A || line == vlcp_pkg::NTSC_F2_LAST)
                    kind = marker;
            end
            else if (ntsc_range && cfg.section == vlcp_pkg::SEC_PROGRAMME)
            begin
                if (line == vlcp_pkg::NTSC_F1_FIRST || line == vlcp_pkg::NTSC_F2_FIRST)
                begin
                    if (!cfg.clv && cfg.mask[vlcp_pkg::MASK_FMPIC])
                        kind = vlcp_pkg::KIND_FMPIC;
                    else if (cfg.clv && cfg.mask[vlcp_pkg::MASK_FMTIME])
                        kind = vlcp_pkg::KIND_FMTIME;
                end
                else if (line == vlcp_pkg::NTSC_F1_WHITE || line == vlcp_pkg::NTSC_F2_WHITE)
                begin
                    if (cfg.mask[vlcp_pkg::MASK_WHITE])
                        kind = vlcp_pkg::KIND_WHITE;
                end
                else
                begin
                    biphase = 1'b1;
                    if (line >= vlcp_pkg::NTSC_F2_USERS)
                        canon = line - vlcp_pkg::NTSC_FOLD;
                end
            end
        end

        // programme area biphase priority on folded lines
        if (biphase)
        begin
            if (!cfg.clv)
            begin
                case (canon)
                    vlcp_pkg::LINE_16:
                    begin
                        if (cfg.mask[vlcp_pkg::MASK_STOP])
                            kind = vlcp_pkg::KIND_STOP;
                        else if (cfg.mask[vlcp_pkg::MASK_STATUS])
                        begin
                            kind = vlcp_pkg::KIND_STATUS;
                            off  = 1'b1;
                        end
                    end
                    vlcp_pkg::LINE_17:
                    begin
                        if (cfg.mask[vlcp_pkg::MASK_PICNUM])
                            kind = vlcp_pkg::KIND_PICNUM;
                        else if (cfg.mask[vlcp_pkg::MASK_STOP])
                            kind = vlcp_pkg::KIND_STOP;
                        else if (cfg.mask[vlcp_pkg::MASK_CHAPTER])
                            kind = vlcp_pkg::KIND_CHAPTER;
                    end
                    vlcp_pkg::LINE_18:
                    begin
                        if (cfg.mask[vlcp_pkg::MASK_CHAPTER])
                            kind = vlcp_pkg::KIND_CHAPTER;
                        else if (cfg.mask[vlcp_pkg::MASK_PICNUM])
                            kind = vlcp_pkg::KIND_PICNUM;
                    end
                    default:
                        kind = vlcp_pkg::KIND_NONE;
                endcase
            end
            else
            begin
                case (canon)
                    vlcp_pkg::LINE_16:
                    begin
                        if (cfg.mask[vlcp_pkg::MASK_CLVPIC])
                            kind = vlcp_pkg::KIND_CLVPIC;
                        else if (cfg.mask[vlcp_pkg::MASK_STATUS])
                        begin
                            kind = vlcp_pkg::KIND_STATUS;
                            off  = 1'b1;
                        end
                    end
                    vlcp_pkg::LINE_17:
                    begin
                        if (cfg.mask[vlcp_pkg::MASK_TIMECODE])
                            kind = vlcp_pkg::KIND_TIMECODE;
                        else if (cfg.mask[vlcp_pkg::MASK_CLVCODE])
                        begin
                            kind = vlcp_pkg::KIND_CLVCODE;
                            off  = cfg.ntsc;
                        end
                    end
                    vlcp_pkg::LINE_18:
                    begin
                        if (cfg.mask[vlcp_pkg::MASK_CHAPTER])
                            kind = vlcp_pkg::KIND_CHAPTER;
                        else if (cfg.mask[vlcp_pkg::MASK_TIMECODE])
                            kind = vlcp_pkg::KIND_TIMECODE;
                    end
                    default:
                        kind = vlcp_pkg::KIND_NONE;
                endcase
            end
        end
    end

    always_comb
    begin
        decision.assigned    = (kind != vlcp_pkg::KIND_NONE);
        decision.kind        = kind;
        decision.is_fm       = (kind == vlcp_pkg::KIND_FMPIC)
                            || (kind == vlcp_pkg::KIND_FMTIME);
        decision.white_flag  = (kind == vlcp_pkg::KIND_WHITE);
        decision.offset_172h = off;
    end

endmodule

`default_nettype wire

// ----- rtl/core/vbi_line_code_placement.sv -----
// channel   | direction | beat contents
// input     | in        | frame_line
// result    | out       | assigned, code_kind, is_fm, white_flag, offset_172h
// config    | in        | cfg_write_en, cfg_index, cfg_data
//
// one beat in and one beat out per cycle while out_stall is low; a beat
// passes an input register, then the decision logic into the result register
// a full result register under out_stall holds the input register, and
// in_stall rises only when both are full
// rst_n clears the valid bits and loads the register reset values
//
// top level of the vbi line code placement block, uses vlcp_pkg and vlcp_decide
`default_nettype none

module vbi_line_code_placement (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [vlcp_pkg::LINE_W-1:0]      frame_line,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  assigned,
    output logic [3:0]                            code_kind,
    output logic                                  is_fm,
    output logic                                  white_flag,
    output logic                                  offset_172h,
    input  wire logic                             cfg_write_en,
    input  wire logic [vlcp_pkg::INDEX_W-1:0]     cfg_index,
    input  wire logic [vlcp_pkg::CFG_W-1:0]       cfg_data
);

    vlcp_pkg::cfg_t                cfg_reg;
    logic                          in_valid_reg;
    logic [vlcp_pkg::LINE_W-1:0]   line_reg;
    logic                          res_valid_reg;
    vlcp_pkg::decision_t           res_reg;
    vlcp_pkg::decision_t           res_next;
    logic                          res_load;
    logic                          in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ntsc    <= 1'b0;
            cfg_reg.clv     <= 1'b0;
            cfg_reg.section <= vlcp_pkg::SEC_PROGRAMME;
            cfg_reg.mask    <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                vlcp_pkg::CFG_VIDEO_STANDARD: cfg_reg.ntsc    <= cfg_data[0];
                vlcp_pkg::CFG_DISC_KIND:      cfg_reg.clv     <= cfg_data[0];
                vlcp_pkg::CFG_SECTION_KIND:   cfg_reg.section <= vlcp_pkg::section_t'(cfg_data[1:0]);
                vlcp_pkg::CFG_PRESENT_MASK:   cfg_reg.mask    <= cfg_data[vlcp_pkg::MASK_W-1:0];
                default:                      cfg_reg.mask    <= cfg_reg.mask;
            endcase
        end
    end

    // result register takes a new beat when empty or draining
    assign res_load = !res_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !res_load;
    assign in_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (res_load)
                res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            line_reg <= frame_line;
        if (res_load && in_valid_reg)
            res_reg <= res_next;
    end

    vlcp_decide u_decide (
        .cfg      (cfg_reg),
        .line     (line_reg),
        .decision (res_next)
    );

    assign out_valid   = res_valid_reg;
    assign assigned    = res_reg.assigned;
    assign code_kind   = res_reg.kind;
    assign is_fm       = res_reg.is_fm;
    assign white_flag  = res_reg.white_flag;
    assign offset_172h = res_reg.offset_172h;

endmodule

`default_nettype wire

// ----- rtl/core/vlcp_checker.sv -----
// port-level checks for vbi_line_code_placement, attached by bind
// depends on vlcp_pkg and vbi_line_code_placement_assert.svh
`default_nettype none

`include "vbi_line_code_placement_assert.svh"

module vlcp_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic                         assigned,
    input wire logic [3:0]                   code_kind,
    input wire logic                         is_fm,
    input wire logic                         white_flag,
    input wire logic                         offset_172h
);

    // an empty beat carries all zero fields
    `VLCP_ASSERT_NOW(a_empty_beat, out_valid && !assigned, code_kind == vlcp_pkg::KIND_NONE && !is_fm && !white_flag && !offset_172h, "unassigned beat with fields set")

    // flags agree with the code kind
    `VLCP_ASSERT_NOW(a_flags_kind, out_valid && (is_fm || white_flag || offset_172h), (is_fm == (code_kind == vlcp_pkg::KIND_FMPIC || code_kind == vlcp_pkg::KIND_FMTIME)) && (white_flag == (code_kind == vlcp_pkg::KIND_WHITE)) && (!offset_172h || code_kind == vlcp_pkg::KIND_STATUS || code_kind == vlcp_pkg::KIND_CLVCODE), "flag does not match code kind")

    // input side backs up only behind a stalled result
    `VLCP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled result")

    // an accepted beat shows up at the output after the input and result registers
    `VLCP_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall && !out_stall, ##1 out_valid, "accepted beat did not reach output")

    // stalled result beat holds
    `VLCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(code_kind) && $stable(assigned), "stalled result changed")

endmodule

bind vbi_line_code_placement vlcp_checker u_vlcp_checker (.*);

`default_nettype wire
